// ----- rtl/lzse_pkg.sv -----
// Package with shared types and constants of the LZ sequence executor.
`timescale 1ns / 1ps

package lzse_pkg;

  localparam int WINDOW_BYTES = 65536;
  localparam int MAX_LITERALS = 16;
  localparam int MAX_MATCH    = 32;

  localparam int LIT_CNT_W = 5;
  localparam int MATCH_W   = 6;
  localparam int OFFSET_W  = 17;
  localparam int LIT_DATA_W = 128;
  localparam int ADDR_W    = $clog2(WINDOW_BYTES);
  localparam int HELD_W    = $clog2(WINDOW_BYTES + 1);
  localparam int CALC_W    = ((ADDR_W > OFFSET_W) ? ADDR_W : OFFSET_W) + 1;

  typedef struct packed {
    logic [LIT_CNT_W-1:0] literal_count;
    logic [63:0]          literal_bytes_low;
    logic [63:0]          literal_bytes_high;
    logic [MATCH_W-1:0]   copy_length;
    logic [OFFSET_W-1:0]  match_offset;
    logic                 end_of_frame;
  } seq_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       frame_done;
    logic       bad_offset;
  } res_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_MREAD,
    ST_MATCH
  } state_t;

  typedef struct packed {
    logic load;
    logic emit_lit;
    logic start_match;
    logic emit_match;
  } ctrl_cmd_t;

  typedef struct packed {
    logic adv;
    logic in_has_lit;
    logic in_has_match;
    logic lit_pending;
    logic lit_last;
    logic match_pending;
    logic match_last;
  } dp_status_t;

endpackage

// ----- rtl/lzse_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lzse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lzse_ctrl.sv -----
// Controller state machine that sequences literal and match emission.
`timescale 1ns / 1ps

module lzse_ctrl import lzse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       seq_valid,
  output logic       seq_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (seq_valid) begin
          if (status.in_has_lit) begin
            state_next = ST_LIT;
          end else if (status.in_has_match) begin
            state_next = ST_MREAD;
          end
        end
      end
      ST_LIT: begin
        if (status.adv && status.lit_last) begin
          state_next = status.match_pending ? ST_MREAD : ST_IDLE;
        end
      end
      ST_MREAD: begin
        state_next = ST_MATCH;
      end
      ST_MATCH: begin
        if (status.adv && status.match_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    seq_ready = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_IDLE: begin
        seq_ready = 1'b1;
        cmd.load  = seq_valid;
      end
      ST_LIT: begin
        cmd.emit_lit = status.adv;
      end
      ST_MREAD: begin
        cmd.start_match = 1'b1;
      end
      ST_MATCH: begin
        cmd.emit_match = status.adv;
      end
      default: begin
        seq_ready = 1'b0;
      end
    endcase
  end

  a_lit_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIT) |-> status.lit_pending)
    else $error("literal state entered with no literal left");

  a_match_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MATCH || state == ST_MREAD) |-> status.match_pending)
    else $error("match state entered with no match byte left");

endmodule

// ----- rtl/lzse_datapath.sv -----
// Datapath with item registers, history window, pointers and output register.
`timescale 1ns / 1ps

module lzse_datapath import lzse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  seq_word_t  seq_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       res_valid,
  input  logic       res_ready,
  output res_word_t  res_data
);

  logic [LIT_DATA_W-1:0] lit_data;
  logic [LIT_CNT_W-1:0]  lit_left;
  logic [MATCH_W-1:0]    match_left;
  logic [OFFSET_W-1:0]   offset;
  logic                  eof;
  logic                  off_one;
  logic                  bad;
  logic [ADDR_W-1:0]     wp;
  logic [ADDR_W-1:0]     wp_next;
  logic [HELD_W-1:0]     held;
  logic [ADDR_W-1:0]     src;
  logic [ADDR_W-1:0]     src_inc;
  logic [ADDR_W-1:0]     src_start;
  logic [7:0]            last_byte;
  logic [7:0]            rdata;
  logic [ADDR_W-1:0]     raddr;
  logic                  emit;
  logic [7:0]            emit_byte;
  logic                  emit_last;
  logic                  offset_ok;
  logic [CALC_W-1:0]     wp_ext;
  logic [CALC_W-1:0]     off_ext;
  logic [LIT_CNT_W-1:0]  lit_clamp;
  logic [MATCH_W-1:0]    match_clamp;

  assign emit = cmd.emit_lit || cmd.emit_match;

  assign lit_clamp = (seq_data.literal_count > LIT_CNT_W'(MAX_LITERALS)) ?
                     LIT_CNT_W'(MAX_LITERALS) : seq_data.literal_count;
  assign match_clamp = (seq_data.copy_length > MATCH_W'(MAX_MATCH)) ?
                       MATCH_W'(MAX_MATCH) : seq_data.copy_length;

  assign wp_next = (wp == ADDR_W'(WINDOW_BYTES - 1)) ? '0 : wp + 1'b1;
  assign src_inc = (src == ADDR_W'(WINDOW_BYTES - 1)) ? '0 : src + 1'b1;

  assign wp_ext  = CALC_W'(wp);
  assign off_ext = CALC_W'(offset);
  assign src_start = (wp_ext >= off_ext) ? ADDR_W'(wp_ext - off_ext) :
                     ADDR_W'(wp_ext + CALC_W'(WINDOW_BYTES) - off_ext);

  assign offset_ok = (offset != '0) && (CALC_W'(offset) <= CALC_W'(held));

  assign raddr = cmd.start_match ? src_start : src_inc;

  lzse_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_history (
    .clk   (clk),
    .we    (emit),
    .waddr (wp),
    .wdata (emit_byte),
    .re    (cmd.start_match || cmd.emit_match),
    .raddr (raddr),
    .rdata (rdata)
  );

  // A distance of one always repeats the byte just recorded, which the RAM
  // cannot return yet when it was written in the previous cycle.
  always_comb begin
    if (cmd.emit_lit) begin
      emit_byte = lit_data[7:0];
      emit_last = (lit_left == LIT_CNT_W'(1)) && (match_left == '0);
    end else begin
      emit_byte = bad ? 8'h00 : (off_one ? last_byte : rdata);
      emit_last = (match_left == MATCH_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lit_data   <= {seq_data.literal_bytes_high, seq_data.literal_bytes_low};
      lit_left   <= lit_clamp;
      match_left <= match_clamp;
      offset     <= seq_data.match_offset;
      eof        <= seq_data.end_of_frame;
      off_one    <= (seq_data.match_offset == OFFSET_W'(1));
    end else if (cmd.emit_lit) begin
      lit_data <= lit_data >> 8;
      lit_left <= lit_left - 1'b1;
    end else if (cmd.emit_match) begin
      match_left <= match_left - 1'b1;
    end
    if (cmd.start_match) begin
      bad <= !offset_ok;
      src <= src_start;
    end else if (cmd.emit_match) begin
      src <= src_inc;
    end
    if (emit) begin
      last_byte <= emit_byte;
      res_data.out_byte     <= emit_byte;
      res_data.last_of_item <= emit_last;
      res_data.frame_done   <= emit_last && eof;
      res_data.bad_offset   <= cmd.emit_match && bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      held      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (emit) begin
        wp <= wp_next;
        if (held < HELD_W'(WINDOW_BYTES)) begin
          held <= held + 1'b1;
        end
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.adv           = !res_valid || res_ready;
    status.in_has_lit    = (seq_data.literal_count != '0);
    status.in_has_match  = (seq_data.copy_length != '0);
    status.lit_pending   = (lit_left != '0);
    status.lit_last      = (lit_left == LIT_CNT_W'(1));
    status.match_pending = (match_left != '0);
    status.match_last    = (match_left == MATCH_W'(1));
  end

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!res_valid || res_ready))
    else $error("byte emitted while the output word is stalled");

  a_held_limit: assert property (@(posedge clk) disable iff (rst)
    held <= HELD_W'(WINDOW_BYTES))
    else $error("held byte count beyond window size");

  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    !emit |=> $stable(wp))
    else $error("write position moved without an emitted byte");

endmodule

// ----- rtl/lz_sequence_executor.sv -----
// Top level of the LZ sequence executor: controller, datapath and their wiring.
//
//   channel   direction  handshake             word
//   sequence  in         seq_valid/seq_ready   seq_data (seq_word_t)
//   result    out        res_valid/res_ready   res_data (res_word_t)
//
// A sequence is loaded in ST_IDLE; its L literals leave in ST_LIT and, if M is
// nonzero, ST_MREAD fetches the first match byte before M bytes leave in ST_MATCH.
// One byte leaves per cycle in those states unless the result side stalls, set by
// the single read port of the history RAM and its registered read.
// Reset clears the write position, the held count, the controller and the
// output valid; the history RAM is not cleared and needs no pass after reset.
// While res_ready is low with an output word valid, the emitting stops and the word holds.
`timescale 1ns / 1ps

module lz_sequence_executor import lzse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      seq_valid,
  output logic      seq_ready,
  input  seq_word_t seq_data,
  output logic      res_valid,
  input  logic      res_ready,
  output res_word_t res_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lzse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .seq_valid (seq_valid),
    .seq_ready (seq_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lzse_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .seq_data  (seq_data),
    .cmd       (cmd),
    .status    (status),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule
